// File: rtl/two_limit_first_fit_packer_core_assert.svh
// Assertion macros shared by the packer RTL.
`ifndef TWO_LIMIT_FIRST_FIT_PACKER_CORE_ASSERT_SVH
`define TWO_LIMIT_FIRST_FIT_PACKER_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define TLFFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TLFFP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/tlffp_pkg.sv
// Shared constants and types of the two-limit first-fit packer.
package tlffp_pkg;

  // Number of bins held in the bin memory
  localparam int unsigned MaxBins = 64;
  localparam int unsigned BinW    = (MaxBins > 1) ? $clog2(MaxBins) : 1;
  localparam int unsigned CntW    = $clog2(MaxBins + 1);

  // Field widths
  localparam int unsigned ValW    = 16;
  localparam int unsigned IdxOutW = 6;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 24;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_LATENCY_LIMIT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MEMORY_LIMIT  = 1'd1;

  localparam logic [ValW-1:0] LATENCY_LIMIT_RST = 16'd50;
  localparam logic [ValW-1:0] MEMORY_LIMIT_RST  = 16'd100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NEW,
    ST_DONE
  } state_e;

  // One bin memory entry: running totals of a bin
  typedef struct packed {
    logic [ValW-1:0] lat;
    logic [ValW-1:0] cost;
  } bin_t;

endpackage

// File: rtl/two_limit_first_fit_packer_core.sv
// Two-limit first-fit bin packer: bin memory, scan sequencer and result register.
//
// Each input beat is placed into the first open bin, in opening order, whose
// cost and latency totals stay within the configured limits; otherwise a new
// bin is opened, or the item is dropped with overflow when all bins are open.
// One result beat leaves for every input beat. The running totals live in a
// single-port-read, single-port-write synchronous memory of MaxBins entries,
// and the sequencer reads one bin per cycle. The result is ready once the scan
// finds an open bin that fits, or after the ST_NEW state when a bin is opened
// or the item is dropped. The next item is taken in the cycle after the result
// is loaded.
// A new item is accepted while the previous result still waits at the output.
// Limits are written through the configuration port; the user must write them
// only while the block is idle, which the block itself does not enforce.
module two_limit_first_fit_packer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration writes
  input  logic                              cfg_we_i,
  input  logic [tlffp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tlffp_pkg::CfgDataW-1:0]    cfg_data_i,
  // Item stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // item_id [15:0], item_cost [31:16], item_latency [47:32]
  input  logic [tlffp_pkg::InDataW-1:0]     s_axis_tdata,
  // start_set [0]
  input  logic [tlffp_pkg::InUserW-1:0]     s_axis_tuser,
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // placed_id [15:0], bin_index [21:16], opened_bin [22], overflow [23]
  output logic [tlffp_pkg::OutDataW-1:0]    m_axis_tdata
);
  import tlffp_pkg::*;

  `include "two_limit_first_fit_packer_core_assert.svh"

  localparam logic [CntW-1:0] MaxBinsCnt = CntW'(MaxBins);

  state_e            state_q, state_d;
  logic [ValW-1:0]   id_q, cost_q, lat_q;
  logic [BinW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [BinW-1:0]   res_bin_q, res_bin_d;
  logic              res_opened_q, res_opened_d;
  logic              res_ovf_q, res_ovf_d;
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [ValW-1:0]   lat_limit_q, mem_limit_q;

  // Bin memory ports
  bin_t              bin_mem [MaxBins];
  logic              rd_en;
  logic [BinW-1:0]   rd_addr;
  bin_t              rd_data_q;
  logic              wr_en;
  logic [BinW-1:0]   wr_addr;
  bin_t              wr_data;

  logic              in_acc;
  logic              out_load;
  logic              start_set;
  logic [CntW-1:0]   idx_next;
  logic              last_bin;
  logic [ValW:0]     sum_cost, sum_lat;
  logic              fits;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign start_set     = s_axis_tuser[0];
  assign out_load      = (state_q == ST_DONE) & (~out_valid_q | m_axis_tready);

  // Fit test on the bin read in the previous cycle
  assign sum_cost = {1'b0, rd_data_q.cost} + {1'b0, cost_q};
  assign sum_lat  = {1'b0, rd_data_q.lat} + {1'b0, lat_q};
  assign fits     = (sum_cost <= {1'b0, mem_limit_q}) && (sum_lat <= {1'b0, lat_limit_q});
  assign idx_next = CntW'(idx_q) + CntW'(1);
  assign last_bin = (idx_next == count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (start_set || count_q == '0) ? ST_NEW : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (fits) begin
          state_d = ST_DONE;
        end else if (last_bin) begin
          state_d = ST_NEW;
        end
      end
      ST_NEW:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory accesses, bin count and result fields
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = '{lat: sum_lat[ValW-1:0], cost: sum_cost[ValW-1:0]};
    idx_d        = idx_q;
    count_d      = count_q;
    res_bin_d    = res_bin_q;
    res_opened_d = res_opened_q;
    res_ovf_d    = res_ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rd_en = 1'b1;
          idx_d = '0;
          if (start_set) begin
            count_d = '0;
          end
        end
      end
      ST_SCAN: begin
        if (fits) begin
          // Add the item to this bin
          wr_en        = 1'b1;
          res_bin_d    = idx_q;
          res_opened_d = 1'b0;
          res_ovf_d    = 1'b0;
        end else if (!last_bin) begin
          // Advance to the next open bin
          rd_en   = 1'b1;
          rd_addr = idx_next[BinW-1:0];
          idx_d   = idx_next[BinW-1:0];
        end
      end
      ST_NEW: begin
        if (count_q == MaxBinsCnt) begin
          // All bins open: drop the item
          res_bin_d    = '0;
          res_opened_d = 1'b0;
          res_ovf_d    = 1'b1;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = count_q[BinW-1:0];
          wr_data      = '{lat: lat_q, cost: cost_q};
          count_d      = count_q + CntW'(1);
          res_bin_d    = count_q[BinW-1:0];
          res_opened_d = 1'b1;
          res_ovf_d    = 1'b0;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Bin memory: synchronous write, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= bin_mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      lat_limit_q <= LATENCY_LIMIT_RST;
      mem_limit_q <= MEMORY_LIMIT_RST;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LATENCY_LIMIT: lat_limit_q <= cfg_data_i;
          CFG_MEMORY_LIMIT:  mem_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    res_bin_q    <= res_bin_d;
    res_opened_q <= res_opened_d;
    res_ovf_q    <= res_ovf_d;
    if (in_acc) begin
      id_q   <= s_axis_tdata[15:0];
      cost_q <= s_axis_tdata[31:16];
      lat_q  <= s_axis_tdata[47:32];
    end
    if (out_load) begin
      out_data_q <= {res_ovf_q, res_opened_q, IdxOutW'(res_bin_q), id_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `TLFFP_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= MaxBinsCnt, "bin count beyond MaxBins")
  `TLFFP_ASSERT(a_scan_in_range, clk_i, rst_ni, (state_q == ST_SCAN) |-> (CntW'(idx_q) < count_q), "scan index past open bins")
  `TLFFP_ASSERT(a_open_counts, clk_i, rst_ni, (state_q == ST_NEW && count_q != MaxBinsCnt) |=> (count_q == $past(count_q) + CntW'(1)), "opening a bin did not advance the count")
  `TLFFP_ASSERT_NEVER(a_ovf_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[23] && (m_axis_tdata[22] || m_axis_tdata[21:16] != '0), "overflow result carries a bin")

endmodule

// File: tb/two_limit_first_fit_packer_core_tb.sv
// Self-checking testbench of the two-limit first-fit packer: directed table, then random sets.
module two_limit_first_fit_packer_core_tb;
  import tlffp_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned HoldAfter  = 360;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned Phases     = 10;
  localparam int unsigned PhaseItems = 140;
  localparam int unsigned TailCycles = 80;

  // One placement, laid out as the result tdata
  typedef struct packed {
    logic                overflow;
    logic                opened;
    logic [IdxOutW-1:0]  bin;
    logic [ValW-1:0]     id;
  } placement_t;

  // One row of the directed table; the placement only counts where typed is set
  typedef struct packed {
    logic               start;
    logic [ValW-1:0]    id;
    logic [ValW-1:0]    cost;
    logic [ValW-1:0]    lat;
    logic               typed;
    logic [IdxOutW-1:0] bin;
    logic               opened;
    logic               overflow;
  } item_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // item_id [15:0], item_cost [31:16], item_latency [47:32]
  logic [InDataW-1:0]  s_axis_tdata;
  // start_set [0]
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // placed_id [15:0], bin_index [21:16], opened_bin [22], overflow [23]
  logic [OutDataW-1:0] m_axis_tdata;

  two_limit_first_fit_packer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Packer state mirrored by the predictor
  logic [ValW-1:0] bin_cost  [MaxBins];
  logic [ValW-1:0] bin_lat   [MaxBins];
  int unsigned     open_bins = 0;
  logic [ValW-1:0] lat_limit = LATENCY_LIMIT_RST;
  logic [ValW-1:0] mem_limit = MEMORY_LIMIT_RST;

  placement_t  placements_due[$];
  int unsigned items_in    = 0;
  int unsigned errors      = 0;
  int unsigned burst_left  = 0;
  bit          gaps_on     = 1'b1;

  // Directed items at the reset limits (lat_limit 50, mem_limit 100)
  item_row_t directed_rows [18] = '{
    '{1'b1, 16'h0000, 16'd0,     16'd0,     1'b1, 6'd0, 1'b1, 1'b0}, // first item opens bin 0
    '{1'b0, 16'hFFFF, 16'hFFFF,  16'hFFFF,  1'b1, 6'd1, 1'b1, 1'b0}, // over both limits alone
    '{1'b0, 16'h1234, 16'd100,   16'd50,    1'b1, 6'd0, 1'b0, 1'b0}, // fills bin 0 exactly
    '{1'b0, 16'h0001, 16'd1,     16'd0,     1'b1, 6'd2, 1'b1, 1'b0},
    '{1'b0, 16'h0002, 16'd0,     16'd50,    1'b1, 6'd2, 1'b0, 1'b0},
    '{1'b0, 16'h0003, 16'd0,     16'd1,     1'b0, 6'd0, 1'b0, 1'b0},
    '{1'b0, 16'h0004, 16'd99,    16'd49,    1'b0, 6'd0, 1'b0, 1'b0},
    '{1'b0, 16'h0005, 16'd101,   16'd0,     1'b0, 6'd0, 1'b0, 1'b0}, // over memory limit alone
    '{1'b0, 16'h0006, 16'd0,     16'd51,    1'b0, 6'd0, 1'b0, 1'b0}, // over latency limit alone
    '{1'b0, 16'hABCD, 16'd0,     16'd0,     1'b1, 6'd0, 1'b0, 1'b0}, // empty item into a full bin
    '{1'b1, 16'h5555, 16'd7,     16'd7,     1'b1, 6'd0, 1'b1, 1'b0}, // start flag mid-set
    '{1'b0, 16'hAAAA, 16'd93,    16'd43,    1'b1, 6'd0, 1'b0, 1'b0},
    '{1'b0, 16'h7FFF, 16'd1,     16'd1,     1'b1, 6'd1, 1'b1, 1'b0},
    '{1'b1, 16'h8000, 16'hFFFF,  16'd0,     1'b1, 6'd0, 1'b1, 1'b0},
    '{1'b1, 16'h0F0F, 16'd0,     16'hFFFF,  1'b1, 6'd0, 1'b1, 1'b0},
    '{1'b0, 16'hF0F0, 16'd0,     16'd0,     1'b0, 6'd0, 1'b0, 1'b0},
    '{1'b0, 16'h0102, 16'h8000,  16'h8000,  1'b0, 6'd0, 1'b0, 1'b0},
    '{1'b0, 16'h1234, 16'd10,    16'd10,    1'b0, 6'd0, 1'b0, 1'b0}  // repeated id
  };

  // Place one item first-fit and update the mirrored bins
  task automatic place_item(input logic start, input logic [ValW-1:0] id,
                            input logic [ValW-1:0] cost, input logic [ValW-1:0] lat,
                            output placement_t res);
    logic [ValW:0] cost_sum;
    logic [ValW:0] lat_sum;
    bit            found;
    res = '0;
    res.id = id;
    found = 1'b0;
    if (start) open_bins = 0;
    for (int i = 0; i < open_bins && !found; i++) begin
      cost_sum = {1'b0, bin_cost[i]} + {1'b0, cost};
      lat_sum  = {1'b0, bin_lat[i]} + {1'b0, lat};
      if (lat_sum <= {1'b0, lat_limit} && cost_sum <= {1'b0, mem_limit}) begin
        bin_cost[i] = cost_sum[ValW-1:0];
        bin_lat[i]  = lat_sum[ValW-1:0];
        res.bin     = IdxOutW'(i);
        found       = 1'b1;
      end
    end
    // Open a new bin, or drop the item when every bin is taken
    if (!found) begin
      if (open_bins < MaxBins) begin
        bin_cost[open_bins] = cost;
        bin_lat[open_bins]  = lat;
        res.bin    = IdxOutW'(open_bins);
        res.opened = 1'b1;
        open_bins++;
      end else begin
        res.overflow = 1'b1;
      end
    end
  endtask

  // Offer one item, hold it until accepted, then record its placement
  task automatic send_item(input logic start, input logic [ValW-1:0] id,
                           input logic [ValW-1:0] cost, input logic [ValW-1:0] lat,
                           input bit typed, input placement_t typed_res);
    placement_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lat, cost, id};
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    place_item(start, id, cost, lat, res);
    placements_due = {placements_due, (typed ? typed_res : res)};
    items_in++;
  endtask

  // Keep a burst going, or drop valid for a short gap
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else if (gaps_on) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // Stop offering and wait for every outstanding placement
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [ValW-1:0] lat, input logic [ValW-1:0] mem);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LATENCY_LIMIT;
    cfg_data_i <= lat;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MEMORY_LIMIT;
    cfg_data_i <= mem;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    lat_limit = lat;
    mem_limit = mem;
  endtask

  // Mostly sizes that fit a few to a bin, now and then zero, all ones or anything
  function automatic logic [ValW-1:0] pick_size(input logic [ValW-1:0] lim);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return ValW'($urandom);
      default: return ValW'($urandom_range(0, int'(lim) / 2 + 1));
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stimulus: reset, directed table, then random sets under several limit settings
  initial begin : stimulus
    logic [ValW-1:0] lat;
    logic [ValW-1:0] mem;
    int unsigned     left;
    int unsigned     span;
    bit              first;
    placement_t      typed_res;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_LATENCY_LIMIT;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[n]) begin
      typed_res = '{overflow: directed_rows[n].overflow, opened: directed_rows[n].opened,
                    bin: directed_rows[n].bin, id: directed_rows[n].id};
      send_item(directed_rows[n].start, directed_rows[n].id, directed_rows[n].cost,
                directed_rows[n].lat, directed_rows[n].typed, typed_res);
      pace();
    end

    for (int p = 0; p < Phases; p++) begin
      drain();
      // Extremes first, then the reset values, then random limits
      case (p)
        0:       begin lat = '0; mem = '0; end
        1:       begin lat = '1; mem = '1; end
        2:       begin lat = '0; mem = '1; end
        3:       begin lat = '1; mem = '0; end
        4:       begin lat = LATENCY_LIMIT_RST; mem = MEMORY_LIMIT_RST; end
        default: begin
          if ($urandom_range(0, 1)) begin
            lat = ValW'($urandom_range(0, 255));
            mem = ValW'($urandom_range(0, 255));
          end else begin
            lat = ValW'($urandom);
            mem = ValW'($urandom);
          end
        end
      endcase
      write_limits(lat, mem);
      gaps_on = (p % 3 != 2);
      left    = PhaseItems;
      first   = 1'b1;
      // Sets start with the start flag; the first set at zero limits overflows the bins
      while (left > 0) begin
        span = (p == 0 && first) ? 100 : $urandom_range(1, 160);
        if (span > left) span = left;
        first = 1'b0;
        left -= span;
        for (int k = 0; k < span; k++) begin
          send_item((k == 0) || ($urandom_range(0, 49) == 0), ValW'($urandom),
                    pick_size(mem_limit), pick_size(lat_limit), 1'b0, '0);
          pace();
        end
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (placements_due.size() != 0) begin
      $error("%0d placements never arrived", placements_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random stall patterns, one long hold-off once the stream is under way
  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    bit          held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      repeat (span) begin
        if (!held && items_in >= HoldAfter) begin
          m_axis_tready <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
          held = 1'b1;
        end
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ~m_axis_tready;
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Compare each result beat with the oldest placement due
  always @(posedge clk_i) begin : result_check
    placement_t seen;
    placement_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata;
      if (placements_due.size() == 0) begin
        $error("result beat %h with no placement due", m_axis_tdata);
        errors++;
      end else begin
        due = placements_due.pop_front();
        if (seen.id !== due.id) begin
          $error("placed_id: expected %h, got %h", due.id, seen.id);
          errors++;
        end
        if (seen.bin !== due.bin) begin
          $error("bin_index: expected %0d, got %0d", due.bin, seen.bin);
          errors++;
        end
        if (seen.opened !== due.opened) begin
          $error("opened_bin: expected %b, got %b", due.opened, seen.opened);
          errors++;
        end
        if (seen.overflow !== due.overflow) begin
          $error("overflow: expected %b, got %b", due.overflow, seen.overflow);
          errors++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: two_limit_first_fit_packer_core.f
+incdir+rtl
rtl/tlffp_pkg.sv
rtl/two_limit_first_fit_packer_core.sv
tb/two_limit_first_fit_packer_core_tb.sv
